// File: src/smf_pkg.sv
// shared types for the sliding window median filter
// no dependencies; used by smf_rank and sliding_window_median_filter
`default_nettype none

package smf_pkg;

   localparam int SampleWidth = 16;

   typedef logic signed [SampleWidth-1:0] sample_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_ROTATE,
      ST_DONE
   } state_type;

   // controls from the sequencer to the rank unit
   typedef struct packed {
      logic count;
      logic first;
   } rank_ctl_type;

endpackage

`default_nettype wire

// File: src/smf_rank.sv
// rank unit: signed less and less-or-equal comparisons feeding two counters
// depends on smf_pkg
`default_nettype none

module smf_rank #(
   parameter int WINDOW = 5
) (
   input  wire logic               clock,
   input  wire smf_pkg::rank_ctl_type rank_ctl,
   input  wire smf_pkg::sample_type   head,
   output smf_pkg::sample_type        cand,
   output logic                    found
);
   import smf_pkg::*;

   localparam int CntWidth = $clog2(WINDOW + 1);
   localparam int MidIdx   = WINDOW / 2;

   sample_type          cand_ff, cand_in;
   logic [CntWidth-1:0] less_ff, less_in;
   logic [CntWidth-1:0] leq_ff, leq_in;

   // candidate is the head on the first step of a pass
   assign cand_in = rank_ctl.first ? head : cand_ff;
   assign cand    = cand_in;

   // count elements below and not above the candidate, self included
   always_comb begin
      less_in = less_ff;
      leq_in  = leq_ff;
      if (rank_ctl.first) begin
         less_in = '0;
         leq_in  = CntWidth'(1);
      end else begin
         less_in = less_ff + CntWidth'(head < cand_ff);
         leq_in  = leq_ff + CntWidth'(head <= cand_ff);
      end
   end

   // candidate sits at the middle sorted index when it spans it
   assign found = (less_in <= CntWidth'(MidIdx)) && (CntWidth'(MidIdx) < leq_in);

   always_ff @(posedge clock) begin
      if (rank_ctl.count) begin
         cand_ff <= cand_in;
         less_ff <= less_in;
         leq_ff  <= leq_in;
      end
   end

endmodule

`default_nettype wire

// File: src/sliding_window_median_filter.sv
// sliding window median filter, top level; depends on smf_pkg and smf_rank
// a request is taken in idle, then p rank passes (p from 1 to WINDOW) run over the
// rotating copy, one compare step per element, with a rotate step between passes
// a new request is taken only once the result is accepted, so result stalls hold it,
// paced by the rank unit walking the rotating copy one element per compare step
// reset: synchronous, clears the window to zeros and returns to idle
`default_nettype none

module sliding_window_median_filter #(
   parameter int WINDOW = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire smf_pkg::sample_type   req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output smf_pkg::sample_type        rsp_median
);
   import smf_pkg::*;

   localparam int StepWidth = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   state_type            state_ff, state_in;
   logic [StepWidth-1:0] step_ff, step_in;
   sample_type           window_ff [WINDOW];
   sample_type           window_in [WINDOW];
   sample_type           ring_ff [WINDOW];
   sample_type           ring_in [WINDOW];
   sample_type           median_ff, median_in;
   rank_ctl_type         rank_ctl;
   sample_type           cand;
   logic                 found;
   logic                 last_step;

   assign last_step = (step_ff == StepWidth'(WINDOW - 1));

   smf_rank #(
      .WINDOW (WINDOW)
   ) u_rank (
      .clock    (clock),
      .rank_ctl (rank_ctl),
      .head     (ring_ff[0]),
      .cand     (cand),
      .found    (found)
   );

   // sequencer: shift in the request, then rank passes over the rotating copy
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      median_in = median_ff;
      rank_ctl  = '0;
      for (int i = 0; i < WINDOW; i++) begin
         window_in[i] = window_ff[i];
         ring_in[i]   = ring_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < WINDOW - 1; i++) begin
                  window_in[i] = window_ff[i+1];
                  ring_in[i]   = window_ff[i+1];
               end
               window_in[WINDOW-1] = req_sample;
               ring_in[WINDOW-1]   = req_sample;
               step_in  = '0;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            rank_ctl.count = 1'b1;
            rank_ctl.first = (step_ff == '0);
            for (int i = 0; i < WINDOW; i++) begin
               ring_in[i] = ring_ff[(i + 1) % WINDOW];
            end
            if (last_step) begin
               step_in = '0;
               if (found) begin
                  median_in = cand;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_ROTATE;
               end
            end else begin
               step_in = step_ff + StepWidth'(1);
            end
         end
         ST_ROTATE: begin
            // bring the next candidate to the head
            for (int i = 0; i < WINDOW; i++) begin
               ring_in[i] = ring_ff[(i + 1) % WINDOW];
            end
            state_in = ST_CMP;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // working copy and result register
   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         ring_ff[i] <= ring_in[i];
      end
      median_ff <= median_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign rsp_median = median_ff;

endmodule

`default_nettype wire
